FILE: rtl/core/mfl_pkg.sv
// Shared types, codes and template tables for the mailbox From-line check.
`timescale 1ns / 1ps
package mfl_pkg;

   typedef struct packed {
      logic [7:0] char_in;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic       is_header;
      logic [1:0] verdict_code;
   } rsp_type;

   typedef enum logic [1:0] {
      VERDICT_HEADER    = 2'd0,
      VERDICT_NO_PREFIX = 2'd1,
      VERDICT_MISSING   = 2'd2,
      VERDICT_BAD_DATE  = 2'd3
   } verdict_type;

   typedef enum logic [7:0] {
      PH_PREFIX  = 8'b0000_0001,
      PH_BLANK1  = 8'b0000_0010,
      PH_SENDER  = 8'b0000_0100,
      PH_BLANK2  = 8'b0000_1000,
      PH_TTYCHK  = 8'b0001_0000,
      PH_TTYWORD = 8'b0010_0000,
      PH_BLANK3  = 8'b0100_0000,
      PH_DATE    = 8'b1000_0000
   } phase_type;

   typedef enum logic [2:0] {
      CLS_NONE  = 3'd0,
      CLS_LOWER = 3'd1,
      CLS_SPACE = 3'd2,
      CLS_DIGIT = 3'd3,
      CLS_OPT   = 3'd4,
      CLS_COLON = 3'd5,
      CLS_UPPER = 3'd6
   } class_type;

   localparam int PLAIN_LEN = 24;
   localparam int ZONED_LEN = 28;
   localparam int PREFIX_LEN = 5;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_T     = 8'h74;
   localparam logic [7:0] CHAR_Y     = 8'h79;

   // Expected character of "From " at each position
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h46;
         3'd1:    ch = 8'h72;
         3'd2:    ch = 8'h6f;
         3'd3:    ch = 8'h6d;
         3'd4:    ch = CHAR_SPACE;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Shared head of both date templates: "Www Mmm dd hh:mm:ss "
   function automatic class_type head_class(input logic [4:0] idx);
      class_type cls;
      unique case (idx)
         5'd0, 5'd4:                      cls = CLS_UPPER;
         5'd1, 5'd2, 5'd5, 5'd6:          cls = CLS_LOWER;
         5'd3, 5'd7, 5'd10, 5'd19:        cls = CLS_SPACE;
         5'd8:                            cls = CLS_OPT;
         5'd9, 5'd11, 5'd12, 5'd14,
         5'd15, 5'd17, 5'd18:             cls = CLS_DIGIT;
         5'd13, 5'd16:                    cls = CLS_COLON;
         default:                         cls = CLS_NONE;
      endcase
      return cls;
   endfunction

   function automatic class_type plain_class(input logic [4:0] idx);
      class_type cls;
      if (idx < 5'd20) begin
         cls = head_class(idx);
      end else if (idx < 5'(PLAIN_LEN)) begin
         cls = CLS_DIGIT;
      end else begin
         cls = CLS_NONE;
      end
      return cls;
   endfunction

   function automatic class_type zoned_class(input logic [4:0] idx);
      class_type cls;
      if (idx < 5'd20) begin
         cls = head_class(idx);
      end else if (idx < 5'd23) begin
         cls = CLS_UPPER;
      end else if (idx == 5'd23) begin
         cls = CLS_SPACE;
      end else if (idx < 5'(ZONED_LEN)) begin
         cls = CLS_DIGIT;
      end else begin
         cls = CLS_NONE;
      end
      return cls;
   endfunction

   function automatic logic is_blank(input logic [7:0] ch);
      return (ch == CHAR_SPACE) || (ch == CHAR_TAB);
   endfunction

endpackage

FILE: rtl/core/mfl_date_match.sv
// Checks one date character against both ctime templates at its position.
`timescale 1ns / 1ps
module mfl_date_match
   import mfl_pkg::*;
(
   input  logic [4:0] date_idx,
   input  logic [7:0] char_in,
   output logic       plain_hit,
   output logic       zoned_hit
);

   logic is_lower;
   logic is_upper;
   logic is_digit;

   assign is_lower = (char_in >= 8'h61) && (char_in <= 8'h7a);
   assign is_upper = (char_in >= 8'h41) && (char_in <= 8'h5a);
   assign is_digit = (char_in >= 8'h30) && (char_in <= 8'h39);

   function automatic logic class_hit(input class_type cls, input logic lo, input logic up,
                                      input logic dg, input logic [7:0] ch);
      logic hit;
      unique case (cls)
         CLS_LOWER: hit = lo;
         CLS_UPPER: hit = up;
         CLS_SPACE: hit = (ch == CHAR_SPACE);
         CLS_DIGIT: hit = dg;
         CLS_OPT:   hit = dg || (ch == CHAR_SPACE);
         CLS_COLON: hit = (ch == CHAR_COLON);
         default:   hit = 1'b0;
      endcase
      return hit;
   endfunction

   assign plain_hit = class_hit(plain_class(date_idx), is_lower, is_upper, is_digit, char_in);
   assign zoned_hit = class_hit(zoned_class(date_idx), is_lower, is_upper, is_digit, char_in);

endmodule

FILE: rtl/core/mfl_parser.sv
// Line parser state: advances once per character and forms the verdict at line end.
`timescale 1ns / 1ps
module mfl_parser
   import mfl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   output rsp_type verdict
);

   phase_type  phase_ff,      phase_in;
   logic [2:0] prefix_idx_ff, prefix_idx_in;
   logic       quote_ff,      quote_in;
   logic [1:0] tty_idx_ff,    tty_idx_in;
   logic [4:0] date_idx_ff,   date_idx_in;
   logic       plain_ok_ff,   plain_ok_in;
   logic       zoned_ok_ff,   zoned_ok_in;
   logic       ended_ff,      ended_in;
   logic       pfail_ff,      pfail_in;

   logic        plain_hit;
   logic        zoned_hit;
   logic        feed;
   logic [7:0]  ch;
   verdict_type code;

   assign ch = item.char_in;

   mfl_date_match u_date_match (
      .date_idx  (date_idx_ff),
      .char_in   (ch),
      .plain_hit (plain_hit),
      .zoned_hit (zoned_hit)
   );

   always_comb begin
      priority if (pfail_ff || (phase_ff == PH_PREFIX)) begin
         code = VERDICT_NO_PREFIX;
      end else if (phase_ff == PH_TTYCHK) begin
         code = VERDICT_BAD_DATE;
      end else if (phase_ff == PH_DATE) begin
         code = ((plain_ok_ff && (date_idx_ff == 5'(PLAIN_LEN))) ||
                 (zoned_ok_ff && (date_idx_ff == 5'(ZONED_LEN)))) ?
                VERDICT_HEADER : VERDICT_BAD_DATE;
      end else begin
         code = VERDICT_MISSING;
      end
   end

   assign verdict.is_header    = (code == VERDICT_HEADER);
   assign verdict.verdict_code = code;

   always_comb begin
      phase_in      = phase_ff;
      prefix_idx_in = prefix_idx_ff;
      quote_in      = quote_ff;
      tty_idx_in    = tty_idx_ff;
      date_idx_in   = date_idx_ff;
      plain_ok_in   = plain_ok_ff;
      zoned_ok_in   = zoned_ok_ff;
      ended_in      = ended_ff;
      pfail_in      = pfail_ff;
      feed          = 1'b0;

      priority if (item.line_end) begin
         phase_in      = PH_PREFIX;
         prefix_idx_in = '0;
         quote_in      = 1'b0;
         tty_idx_in    = '0;
         date_idx_in   = '0;
         plain_ok_in   = 1'b1;
         zoned_ok_in   = 1'b1;
         ended_in      = 1'b0;
         pfail_in      = 1'b0;
      end else if (ended_ff || pfail_ff) begin
         // drop everything up to the line end
      end else if (ch == 8'h00) begin
         ended_in = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_PREFIX: begin
               if (ch == prefix_char(prefix_idx_ff)) begin
                  prefix_idx_in = prefix_idx_ff + 3'd1;
                  if (prefix_idx_ff == 3'(PREFIX_LEN - 1)) begin
                     phase_in = PH_BLANK1;
                  end
               end else begin
                  pfail_in = 1'b1;
               end
            end
            PH_BLANK1, PH_SENDER, PH_TTYWORD: begin
               // a blank outside quotes closes the word
               if (phase_ff == PH_BLANK1 && is_blank(ch)) begin
                  phase_in = PH_BLANK1;
               end else if (quote_ff) begin
                  phase_in = (phase_ff == PH_BLANK1) ? PH_SENDER : phase_ff;
                  if (ch == CHAR_QUOTE) begin
                     quote_in = 1'b0;
                  end
               end else if (is_blank(ch)) begin
                  phase_in = (phase_ff == PH_TTYWORD) ? PH_BLANK3 : PH_BLANK2;
               end else begin
                  phase_in = (phase_ff == PH_BLANK1) ? PH_SENDER : phase_ff;
                  if (ch == CHAR_QUOTE) begin
                     quote_in = 1'b1;
                  end
               end
            end
            PH_BLANK2: begin
               if (!is_blank(ch)) begin
                  if (ch == CHAR_T) begin
                     phase_in   = PH_TTYCHK;
                     tty_idx_in = 2'd1;
                  end else begin
                     phase_in = PH_DATE;
                     feed     = 1'b1;
                  end
               end
            end
            PH_TTYCHK: begin
               if (tty_idx_ff == 2'd1 && ch == CHAR_T) begin
                  tty_idx_in = 2'd2;
               end else if (tty_idx_ff == 2'd2 && ch == CHAR_Y) begin
                  tty_idx_in = 2'd3;
                  phase_in   = PH_TTYWORD;
               end else begin
                  phase_in    = PH_DATE;
                  plain_ok_in = 1'b0;
                  zoned_ok_in = 1'b0;
               end
            end
            PH_BLANK3: begin
               if (!is_blank(ch)) begin
                  phase_in = PH_DATE;
                  feed     = 1'b1;
               end
            end
            PH_DATE: begin
               feed = 1'b1;
            end
            default: begin
               phase_in    = PH_DATE;
               plain_ok_in = 1'b0;
               zoned_ok_in = 1'b0;
            end
         endcase
      end

      if (feed) begin
         plain_ok_in = plain_ok_ff & plain_hit;
         zoned_ok_in = zoned_ok_ff & zoned_hit;
         if (date_idx_ff != 5'd31) begin
            date_idx_in = date_idx_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_PREFIX;
         prefix_idx_ff <= '0;
         quote_ff      <= 1'b0;
         tty_idx_ff    <= '0;
         date_idx_ff   <= '0;
         plain_ok_ff   <= 1'b1;
         zoned_ok_ff   <= 1'b1;
         ended_ff      <= 1'b0;
         pfail_ff      <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         prefix_idx_ff <= prefix_idx_in;
         quote_ff      <= quote_in;
         tty_idx_ff    <= tty_idx_in;
         date_idx_ff   <= date_idx_in;
         plain_ok_ff   <= plain_ok_in;
         zoned_ok_ff   <= zoned_ok_in;
         ended_ff      <= ended_in;
         pfail_ff      <= pfail_in;
      end
   end

endmodule

FILE: rtl/core/mailbox_from_line_check_top.sv
// Top level of the mailbox From-line check: input register, parser, result register.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_type (char_in, line_end)
//   rsp_      out        rsp_valid/rsp_stall  rsp_type (is_header, verdict_code)
//
// One char per cycle unless stalled; a verdict shows the cycle after its line end is taken.
// The parser state register updates once per transaction and limits the rate to one.
// Synchronous reset clears the parser to the start of a line and empties both registers.
// A stalled verdict holds the line end in the input register; other characters keep moving.
`timescale 1ns / 1ps
module mailbox_from_line_check_top
   import mfl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;

   logic    out_free;
   logic    advance;
   rsp_type verdict;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_item_ff.line_end || out_free);
   assign req_stall = in_valid_ff && !advance;

   mfl_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (in_item_ff),
      .verdict (verdict)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance && in_item_ff.line_end) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_payload;
      end
      if (advance && in_item_ff.line_end) begin
         out_item_ff <= verdict;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   a_verdict_shown: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.line_end) |=> rsp_valid)
      else $error("line end taken but no verdict presented");

   a_header_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.is_header == (rsp_payload.verdict_code == VERDICT_HEADER)))
      else $error("header flag disagrees with verdict code");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_item_ff.line_end && rsp_valid && rsp_stall))
      else $error("input stalled without a blocked verdict");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("pending verdict overwritten");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the mailbox From-line check: random lines against a built-in parser.
`timescale 1ns / 1ps
module testbench;
   import mfl_pkg::*;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = "0";
   localparam logic [7:0] CHAR_NINE  = "9";
   localparam logic [7:0] CHAR_UPA   = "A";
   localparam logic [7:0] CHAR_UPZ   = "Z";
   localparam logic [7:0] CHAR_LOWA  = "a";
   localparam logic [7:0] CHAR_LOWZ  = "z";
   localparam string      FROM_TEXT  = "From ";
   localparam int         DATE_CAP   = 31;
   localparam int         DRAIN_CYCLES = 8;

   // shape of the third word of a generated line
   localparam int WORD3_NONE = 0;
   localparam int WORD3_TTY  = 1;
   localparam int WORD3_BADT = 2;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   mailbox_from_line_check_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #10 clock = ~clock;

   // parser state as the bench sees it
   phase_type parse_at;
   int        from_pos;
   bit        in_quote;
   int        tty_pos;
   int        date_cnt;
   bit        plain_ok;
   bit        zoned_ok;
   bit        text_over;
   bit        from_bad;

   rsp_type    verdicts_due[$];
   rsp_type    verdict_want;
   logic [7:0] line_buf[$];
   int         chars_sent = 0;
   int         mismatch_count = 0;
   bit         idle_on = 1'b0;
   bit         stall_on = 1'b0;
   int         rsp_wait = 0;
   bit         rsp_drawn = 1'b0;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   task automatic clear_parser();
      parse_at  = PH_PREFIX;
      from_pos  = 0;
      in_quote  = 1'b0;
      tty_pos   = 0;
      date_cnt  = 0;
      plain_ok  = 1'b1;
      zoned_ok  = 1'b1;
      text_over = 1'b0;
      from_bad  = 1'b0;
   endtask

   function automatic class_type date_class(input bit zoned, input int pos);
      class_type cls;
      case (pos)
         0, 4:                       cls = CLS_UPPER;
         1, 2, 5, 6:                 cls = CLS_LOWER;
         3, 7, 10, 19:               cls = CLS_SPACE;
         8:                          cls = CLS_OPT;
         13, 16:                     cls = CLS_COLON;
         9, 11, 12, 14, 15, 17, 18:  cls = CLS_DIGIT;
         20, 21, 22:                 cls = zoned ? CLS_UPPER : CLS_DIGIT;
         23:                         cls = zoned ? CLS_SPACE : CLS_DIGIT;
         24, 25, 26, 27:             cls = zoned ? CLS_DIGIT : CLS_NONE;
         default:                    cls = CLS_NONE;
      endcase
      return cls;
   endfunction

   function automatic bit char_fits(input class_type cls, input logic [7:0] c);
      bit digit;
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      case (cls)
         CLS_LOWER: return (c >= CHAR_LOWA) && (c <= CHAR_LOWZ);
         CLS_UPPER: return (c >= CHAR_UPA) && (c <= CHAR_UPZ);
         CLS_SPACE: return c == CHAR_SPACE;
         CLS_DIGIT: return digit;
         CLS_OPT:   return digit || (c == CHAR_SPACE);
         CLS_COLON: return c == CHAR_COLON;
         default:   return 1'b0;
      endcase
   endfunction

   function automatic bit blank_char(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   task automatic feed_date(input logic [7:0] c);
      plain_ok = plain_ok && char_fits(date_class(1'b0, date_cnt), c);
      zoned_ok = zoned_ok && char_fits(date_class(1'b1, date_cnt), c);
      if (date_cnt < DATE_CAP) date_cnt++;
   endtask

   // word body: quotes may hide blanks, an unquoted blank ends the word
   task automatic word_step(input logic [7:0] c, input phase_type after);
      if (in_quote) begin
         if (c == CHAR_QUOTE) in_quote = 1'b0;
      end else if (blank_char(c)) begin
         parse_at = after;
      end else if (c == CHAR_QUOTE) begin
         in_quote = 1'b1;
      end
   endtask

   task automatic date_broken();
      parse_at = PH_DATE;
      plain_ok = 1'b0;
      zoned_ok = 1'b0;
   endtask

   task automatic advance_parser(input req_type item);
      logic [7:0]  c;
      verdict_type code;
      rsp_type     v;
      c = item.char_in;
      if (item.line_end) begin
         if (from_bad || parse_at == PH_PREFIX) begin
            code = VERDICT_NO_PREFIX;
         end else if (parse_at == PH_TTYCHK) begin
            code = VERDICT_BAD_DATE;
         end else if (parse_at == PH_DATE) begin
            code = ((plain_ok && date_cnt == PLAIN_LEN) || (zoned_ok && date_cnt == ZONED_LEN))
                   ? VERDICT_HEADER : VERDICT_BAD_DATE;
         end else begin
            code = VERDICT_MISSING;
         end
         v.is_header    = (code == VERDICT_HEADER);
         v.verdict_code = code;
         verdicts_due.push_back(v);
         clear_parser();
      end else if (!text_over && !from_bad) begin
         if (c == CHAR_NUL) begin
            text_over = 1'b1;
         end else begin
            case (parse_at)
               PH_PREFIX: begin
                  if (from_pos < PREFIX_LEN && c == FROM_TEXT[from_pos]) begin
                     from_pos++;
                     if (from_pos == PREFIX_LEN) parse_at = PH_BLANK1;
                  end else begin
                     from_bad = 1'b1;
                  end
               end
               PH_BLANK1: begin
                  if (!blank_char(c)) begin
                     parse_at = PH_SENDER;
                     word_step(c, PH_BLANK2);
                  end
               end
               PH_SENDER: word_step(c, PH_BLANK2);
               PH_BLANK2: begin
                  if (!blank_char(c)) begin
                     if (c == CHAR_T) begin
                        parse_at = PH_TTYCHK;
                        tty_pos  = 1;
                     end else begin
                        parse_at = PH_DATE;
                        feed_date(c);
                     end
                  end
               end
               PH_TTYCHK: begin
                  if (tty_pos == 1 && c == CHAR_T) begin
                     tty_pos = 2;
                  end else if (tty_pos == 2 && c == CHAR_Y) begin
                     tty_pos  = 3;
                     parse_at = PH_TTYWORD;
                  end else begin
                     date_broken();
                  end
               end
               PH_TTYWORD: word_step(c, PH_BLANK3);
               PH_BLANK3: begin
                  if (!blank_char(c)) begin
                     parse_at = PH_DATE;
                     feed_date(c);
                  end
               end
               PH_DATE: feed_date(c);
               default: date_broken();
            endcase
         end
      end
   endtask

   // Drive one transaction at the falling edge and hold it until taken.
   task automatic send_item(input logic [7:0] ch, input logic last);
      int      gap;
      req_type item;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      item.char_in  = ch;
      item.line_end = last;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      advance_parser(item);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_line();
      logic [7:0] junk;
      foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
      junk = 8'($urandom_range(0, 255));
      send_item(junk, 1'b1);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic put_blanks();
      int n;
      n = $urandom_range(1, 3);
      repeat (n) line_buf.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
   endtask

   function automatic logic [7:0] word_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255));
      while (blank_char(b) || b == CHAR_QUOTE);
      return b;
   endfunction

   function automatic logic [7:0] pick_range(input logic [7:0] lo, input logic [7:0] hi);
      logic [7:0] b;
      b = 8'(lo + $urandom_range(0, hi - lo));
      return b;
   endfunction

   task automatic put_sender();
      int n;
      int k;
      n = $urandom_range(1, 6);
      repeat (n) begin
         if ($urandom_range(0, 5) == 0) begin
            line_buf.push_back(CHAR_QUOTE);
            k = $urandom_range(0, 4);
            repeat (k) line_buf.push_back($urandom_range(0, 2) == 0 ? CHAR_SPACE : word_byte());
            line_buf.push_back(CHAR_QUOTE);
         end else begin
            line_buf.push_back(word_byte());
         end
      end
   endtask

   task automatic put_digits(input int n);
      repeat (n) line_buf.push_back(pick_range(CHAR_ZERO, CHAR_NINE));
   endtask

   task automatic put_date(input bit zoned);
      repeat (2) begin
         line_buf.push_back(pick_range(CHAR_UPA, CHAR_UPZ));
         repeat (2) line_buf.push_back(pick_range(CHAR_LOWA, CHAR_LOWZ));
         line_buf.push_back(CHAR_SPACE);
      end
      line_buf.push_back($urandom_range(0, 1) ? CHAR_SPACE : pick_range(CHAR_ZERO, CHAR_NINE));
      put_digits(1);
      line_buf.push_back(CHAR_SPACE);
      put_digits(2);
      line_buf.push_back(CHAR_COLON);
      put_digits(2);
      line_buf.push_back(CHAR_COLON);
      put_digits(2);
      line_buf.push_back(CHAR_SPACE);
      if (zoned) begin
         repeat (3) line_buf.push_back(pick_range(CHAR_UPA, CHAR_UPZ));
         line_buf.push_back(CHAR_SPACE);
      end
      put_digits(4);
   endtask

   task automatic build_header(input int word3, input bit with_date);
      int k;
      line_buf.delete();
      put_text(FROM_TEXT);
      if ($urandom_range(0, 3) == 0) put_blanks();
      put_sender();
      put_blanks();
      if (word3 != WORD3_NONE) begin
         line_buf.push_back(CHAR_T);
         if (word3 == WORD3_TTY) begin
            line_buf.push_back(CHAR_T);
            line_buf.push_back(CHAR_Y);
         end else begin
            line_buf.push_back(pick_range(CHAR_LOWA, CHAR_LOWZ));
         end
         k = $urandom_range(0, 3);
         repeat (k) line_buf.push_back(word_byte());
         if (with_date) put_blanks();
      end
      if (with_date) put_date($urandom_range(0, 1));
   endtask

   // Vary the pacing per line so that runs without gaps or stalls occur too.
   task automatic pick_pace();
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
   endtask

   task automatic test_short_lines();
      idle_on  = 1'b1;
      stall_on = 1'b1;
      // bare line end, then a cut-off prefix
      line_buf.delete();
      send_line();
      put_text("Fr");
      send_line();
      // zero byte inside the prefix hides the rest
      line_buf.delete();
      put_text("Fr");
      line_buf.push_back(CHAR_NUL);
      put_text("om");
      send_line();
      // top-bit byte breaks the prefix
      line_buf.delete();
      put_text("Fr");
      line_buf.push_back(8'hff);
      line_buf.push_back(8'h80);
      send_line();
      // prefix with nothing after
      line_buf.delete();
      put_text(FROM_TEXT);
      send_line();
      // third word starting with a lone t
      line_buf.delete();
      put_text("From a t");
      send_line();
   endtask

   task automatic test_headers();
      while (chars_sent < 900) begin
         pick_pace();
         build_header($urandom_range(0, 2) == 0 ? WORD3_TTY : WORD3_NONE, 1'b1);
         send_line();
      end
   endtask

   task automatic test_damaged_headers();
      int         pos;
      int         n;
      logic [7:0] b;
      while (chars_sent < 1300) begin
         pick_pace();
         build_header($urandom_range(0, 2) == 0 ? WORD3_TTY : WORD3_NONE, 1'b1);
         pos = $urandom_range(0, line_buf.size() - 1);
         case ($urandom_range(0, 6))
            0: begin
               b = 8'($urandom_range(1, 255));
               line_buf[pos] = b;
            end
            1: line_buf.insert(pos, CHAR_NUL);
            2: begin
               n = $urandom_range(0, line_buf.size() - 1);
               while (line_buf.size() > n) void'(line_buf.pop_back());
            end
            3: begin
               // long line: extra bytes may drive the date count up to its ceiling
               n = $urandom_range(1, 40);
               repeat (n) begin
                  b = 8'($urandom_range(1, 255));
                  line_buf.push_back(b);
               end
            end
            4: line_buf.insert(pos, CHAR_QUOTE);
            5: build_header(WORD3_BADT, 1'b1);
            default: build_header(WORD3_TTY, 1'b0);
         endcase
         send_line();
      end
   endtask

   task automatic test_noise();
      int         n;
      logic [7:0] b;
      while (chars_sent < 1550) begin
         pick_pace();
         line_buf.delete();
         n = $urandom_range(0, PREFIX_LEN);
         for (int i = 0; i < n; i++) line_buf.push_back(FROM_TEXT[i]);
         n = $urandom_range(0, 30);
         repeat (n) begin
            b = ($urandom_range(0, 7) == 0) ? CHAR_NUL : 8'($urandom_range(1, 255));
            line_buf.push_back(b);
         end
         send_line();
      end
   endtask

   // result side: draw a stall for each verdict once it shows
   always @(negedge clock) begin
      if (rsp_valid && !rsp_drawn) begin
         rsp_wait  = stall_on ? $urandom_range(0, 4) : 0;
         rsp_drawn = 1'b1;
      end
      if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_drawn = 1'b0;
         if (verdicts_due.size() == 0) begin
            report_mismatch($sformatf("verdict %0d with none outstanding",
                                      rsp_payload.verdict_code));
         end else begin
            verdict_want = verdicts_due.pop_front();
            if (rsp_payload.is_header !== verdict_want.is_header) begin
               report_mismatch($sformatf("is_header %b, wanted %b",
                                         rsp_payload.is_header, verdict_want.is_header));
            end
            if (rsp_payload.verdict_code !== verdict_want.verdict_code) begin
               report_mismatch($sformatf("verdict_code %0d, wanted %0d",
                                         rsp_payload.verdict_code,
                                         verdict_want.verdict_code));
            end
         end
      end
   end

   initial begin
      clear_parser();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_short_lines();
      test_headers();
      test_damaged_headers();
      test_noise();
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
